FILE: rtl/core/crrd_pkg.sv
// shared constants and codes for the consumer group round-robin dispatcher
package crrd_pkg;

    // table geometry
    localparam int MAX_GROUPS      = 8;
    localparam int SLOTS_PER_GROUP = 10;
    localparam int GRP_W           = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W           = $clog2(MAX_GROUPS + 1);
    localparam int SLOT_W          = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
    localparam int TOT_W           = $clog2(SLOTS_PER_GROUP + 1);
    localparam int ADDR_W          = GRP_W + SLOT_W;
    localparam int MEM_DEPTH       = MAX_GROUPS << SLOT_W;

    // field widths
    localparam int HDL_W  = 16;
    localparam int TAG_W  = 32;
    localparam int GID_W  = 16;
    localparam int MEMB_W = 4;
    localparam int LIM_W  = 4;

    localparam logic [LIM_W-1:0] LIMIT_RST = 4'd10;

    // request codes
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NO_CONS   = 2'd3;

    // one member entry in the slot memory
    typedef struct packed {
        logic [HDL_W-1:0]  handle;
        logic [MEMB_W-1:0] number;
    } t_member;

endpackage

FILE: rtl/core/consumer_group_round_robin_dispatch.sv
// top level: consumer group table with round-robin dispatch
// Requests are taken one at a time; o_in_stall stays high until every result of the
// current request has entered the output register. Group metadata sits in a small
// table reached through an order list (front = newest group), and member slots live
// in one synchronous memory with a registered read, so group moves cost only a
// rewrite of the order list. Register scans the groups in list order and opens a new
// group when none has room; remove reads and compares members one at a time and
// shifts the members after the hit down to close the gap; dispatch reads one member
// per group and emits one result per group served, or a single no-consumers result
// when there are no groups. The next request is taken in the cycle after the last
// result enters the output register. No clearing pass after reset is needed.
module consumer_group_round_robin_dispatch (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [crrd_pkg::LIM_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [crrd_pkg::HDL_W-1:0]  i_consumer_handle,
    input  logic [crrd_pkg::TAG_W-1:0]  i_message_tag,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [crrd_pkg::GID_W-1:0]  o_group_number,
    output logic [crrd_pkg::MEMB_W-1:0] o_member_number,
    output logic [crrd_pkg::HDL_W-1:0]  o_target_handle,
    output logic [crrd_pkg::TAG_W-1:0]  o_tag_out,
    output logic                        o_last
);
    import crrd_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_REG_SCAN = 4'd1;
    localparam logic [3:0] S_REG_NEW  = 4'd2;
    localparam logic [3:0] S_REM_RD   = 4'd3;
    localparam logic [3:0] S_REM_CHK  = 4'd4;
    localparam logic [3:0] S_SHF_RD   = 4'd5;
    localparam logic [3:0] S_SHF_WR   = 4'd6;
    localparam logic [3:0] S_REM_FIN  = 4'd7;
    localparam logic [3:0] S_DSP_RD   = 4'd8;
    localparam logic [3:0] S_DSP_OUT  = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    // control and request registers
    logic [3:0]        r_state;
    logic [HDL_W-1:0]  r_hdl;
    logic [TAG_W-1:0]  r_tag;
    logic [GRP_W-1:0]  r_pos;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_hit;
    logic [CNT_W-1:0]  r_used;
    logic [LIM_W-1:0]  r_limit;
    logic [GID_W-1:0]  r_next_id;
    logic [1:0]        r_pend_st;
    logic [GID_W-1:0]  r_pend_grp;

    // group table, addressed by physical group
    logic [GRP_W-1:0]  r_order [MAX_GROUPS];
    logic [GID_W-1:0]  r_ident [MAX_GROUPS];
    logic [TOT_W-1:0]  r_total [MAX_GROUPS];
    logic [SLOT_W-1:0] r_rr    [MAX_GROUPS];

    // member slot memory
    t_member           mem [MEM_DEPTH];
    t_member           r_rdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_member           mem_wdata;

    // output register
    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic [GID_W-1:0]  r_ogrp;
    logic [MEMB_W-1:0] r_omemb;
    logic [HDL_W-1:0]  r_ohdl;
    logic [TAG_W-1:0]  r_otag;
    logic              r_olast;

    logic              out_ok;
    logic              out_load;
    logic [GRP_W-1:0]  cur_phys;
    logic [GRP_W-1:0]  new_phys;
    logic [TOT_W-1:0]  cur_total;
    logic [SLOT_W-1:0] cur_rr;
    logic [TOT_W-1:0]  eff_limit;
    logic              last_pos;
    logic              slot_more;
    logic [TOT_W-1:0]  rem_total;
    logic [SLOT_W-1:0] rr_inc;

    assign out_ok    = !r_ovalid || !i_out_stall;
    assign out_load  = out_ok && (r_state == S_DSP_OUT || r_state == S_EMIT);
    assign cur_phys  = r_order[r_pos];
    assign new_phys  = r_order[r_used[GRP_W-1:0]];
    assign cur_total = r_total[cur_phys];
    assign cur_rr    = r_rr[cur_phys];
    assign last_pos  = (CNT_W'(r_pos) + CNT_W'(1)) == r_used;
    assign slot_more = (TOT_W'(r_slot) + TOT_W'(1)) < cur_total;
    assign rem_total = cur_total - TOT_W'(1);
    assign rr_inc    = ((TOT_W'(cur_rr) + TOT_W'(1)) == cur_total) ? '0 : cur_rr + SLOT_W'(1);

    // limit clamped to the legal range
    always_comb begin
        if (r_limit == '0) begin
            eff_limit = TOT_W'(1);
        end else if ({1'b0, r_limit} > (LIM_W+1)'(SLOTS_PER_GROUP)) begin
            eff_limit = TOT_W'(SLOTS_PER_GROUP);
        end else begin
            eff_limit = TOT_W'(r_limit);
        end
    end

    // memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = {cur_phys, r_slot};
        mem_we    = 1'b0;
        mem_waddr = {cur_phys, cur_total[SLOT_W-1:0]};
        mem_wdata = '{handle: r_hdl, number: MEMB_W'(cur_total)};
        case (r_state)
            S_REG_SCAN: begin
                mem_we = cur_total < eff_limit;
            end
            S_REG_NEW: begin
                mem_we    = 1'b1;
                mem_waddr = {new_phys, {SLOT_W{1'b0}}};
                mem_wdata = '{handle: r_hdl, number: '0};
            end
            S_REM_RD, S_SHF_RD: begin
                mem_re = 1'b1;
            end
            S_SHF_WR: begin
                mem_we    = 1'b1;
                mem_waddr = {cur_phys, r_slot - SLOT_W'(1)};
                mem_wdata = r_rdata;
            end
            S_DSP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = {cur_phys, cur_rr};
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // sequencer, group table and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_limit   <= LIMIT_RST;
            r_next_id <= '0;
            r_ovalid  <= 1'b0;
            r_pos     <= '0;
            r_slot    <= '0;
            for (int k = 0; k < MAX_GROUPS; k++) begin
                r_order[k] <= GRP_W'(k);
                r_ident[k] <= '0;
                r_total[k] <= '0;
                r_rr[k]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            // output valid: loaded by a result, cleared once taken
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_hdl  <= i_consumer_handle;
                        r_tag  <= i_message_tag;
                        r_pos  <= '0;
                        r_slot <= '0;
                        case (i_cmd)
                            CMD_REGISTER: begin
                                r_state <= (r_used == '0) ? S_REG_NEW : S_REG_SCAN;
                            end
                            CMD_REMOVE: begin
                                r_pend_st  <= ST_NOT_FOUND;
                                r_pend_grp <= '0;
                                r_state    <= (r_used == '0) ? S_EMIT : S_REM_RD;
                            end
                            CMD_DISPATCH: begin
                                r_pend_st  <= ST_NO_CONS;
                                r_pend_grp <= '0;
                                r_state    <= (r_used == '0) ? S_EMIT : S_DSP_RD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                // first group in list order with room takes the handle
                S_REG_SCAN: begin
                    if (cur_total < eff_limit) begin
                        r_total[cur_phys] <= cur_total + TOT_W'(1);
                        r_pend_st         <= ST_OK;
                        r_pend_grp        <= r_ident[cur_phys];
                        r_state           <= S_EMIT;
                    end else if (last_pos) begin
                        if (r_used == CNT_W'(MAX_GROUPS)) begin
                            r_pend_st  <= ST_FULL;
                            r_pend_grp <= '0;
                            r_state    <= S_EMIT;
                        end else begin
                            r_state <= S_REG_NEW;
                        end
                    end else begin
                        r_pos <= r_pos + GRP_W'(1);
                    end
                end
                // open a new group at the front
                S_REG_NEW: begin
                    for (int k = 1; k < MAX_GROUPS; k++) begin
                        if (CNT_W'(k) <= r_used) begin
                            r_order[k] <= r_order[k-1];
                        end
                    end
                    r_order[0]        <= new_phys;
                    r_ident[new_phys] <= r_next_id;
                    r_total[new_phys] <= TOT_W'(1);
                    r_rr[new_phys]    <= '0;
                    r_next_id         <= r_next_id + GID_W'(1);
                    r_used            <= r_used + CNT_W'(1);
                    r_pend_st         <= ST_OK;
                    r_pend_grp        <= r_next_id;
                    r_state           <= S_EMIT;
                end
                S_REM_RD: begin
                    r_state <= S_REM_CHK;
                end
                // compare one member against the handle
                S_REM_CHK: begin
                    if (r_rdata.handle == r_hdl) begin
                        r_hit <= r_slot;
                        if (slot_more) begin
                            r_slot  <= r_slot + SLOT_W'(1);
                            r_state <= S_SHF_RD;
                        end else begin
                            r_state <= S_REM_FIN;
                        end
                    end else if (slot_more) begin
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= S_REM_RD;
                    end else if (last_pos) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_pos   <= r_pos + GRP_W'(1);
                        r_slot  <= '0;
                        r_state <= S_REM_RD;
                    end
                end
                S_SHF_RD: begin
                    r_state <= S_SHF_WR;
                end
                // move one member down to close the gap
                S_SHF_WR: begin
                    if (slot_more) begin
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= S_SHF_RD;
                    end else begin
                        r_state <= S_REM_FIN;
                    end
                end
                // count, pointer and group drop after a remove
                S_REM_FIN: begin
                    r_total[cur_phys] <= rem_total;
                    if (rem_total == '0) begin
                        r_rr[cur_phys] <= '0;
                    end else if (cur_rr > r_hit) begin
                        r_rr[cur_phys] <= cur_rr - SLOT_W'(1);
                    end else if (TOT_W'(cur_rr) >= rem_total) begin
                        r_rr[cur_phys] <= '0;
                    end
                    r_pend_st  <= ST_OK;
                    r_pend_grp <= r_ident[cur_phys];
                    if (rem_total == '0) begin
                        for (int k = 0; k < MAX_GROUPS - 1; k++) begin
                            if (GRP_W'(k) >= r_pos && CNT_W'(k) + CNT_W'(1) < r_used) begin
                                r_order[k] <= r_order[k+1];
                            end
                        end
                        r_order[GRP_W'(r_used - CNT_W'(1))] <= cur_phys;
                        r_ident[cur_phys] <= '0;
                        r_used            <= r_used - CNT_W'(1);
                    end
                    r_state <= S_EMIT;
                end
                S_DSP_RD: begin
                    r_state <= S_DSP_OUT;
                end
                // one dispatch result per group, front to back
                S_DSP_OUT: begin
                    if (out_ok) begin
                        r_ostatus      <= ST_OK;
                        r_ogrp         <= r_ident[cur_phys];
                        r_omemb        <= r_rdata.number;
                        r_ohdl         <= r_rdata.handle;
                        r_otag         <= r_tag;
                        r_olast        <= last_pos;
                        r_rr[cur_phys] <= rr_inc;
                        if (last_pos) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + GRP_W'(1);
                            r_state <= S_DSP_RD;
                        end
                    end
                end
                // single result of a request
                S_EMIT: begin
                    if (out_ok) begin
                        r_ostatus <= r_pend_st;
                        r_ogrp    <= r_pend_grp;
                        r_omemb   <= '0;
                        r_ohdl    <= '0;
                        r_otag    <= (r_pend_st == ST_NO_CONS) ? r_tag : '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_group_number  = r_ogrp;
    assign o_member_number = r_omemb;
    assign o_target_handle = r_ohdl;
    assign o_tag_out       = r_otag;
    assign o_last          = r_olast;

endmodule

FILE: rtl/core/crrd_checker.sv
// port-level checks for the dispatcher and their binding
module crrd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_status,
    input logic [crrd_pkg::GID_W-1:0]  o_group_number,
    input logic [crrd_pkg::MEMB_W-1:0] o_member_number,
    input logic [crrd_pkg::HDL_W-1:0]  o_target_handle,
    input logic [crrd_pkg::TAG_W-1:0]  o_tag_out,
    input logic                        o_last
);
    import crrd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // no consumers is always a single closing result
    a_nocons_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NO_CONS |-> o_last && o_member_number == '0)
        else $error("no-consumers result malformed");

    // failed register or remove carries no member or tag
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL)
        |-> o_last && o_target_handle == '0 && o_tag_out == '0 && o_group_number == '0)
        else $error("failed result carries data");

    // nothing is presented right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind consumer_group_round_robin_dispatch crrd_checker u_crrd_checker (.*);
